### hdl/sdt_pkg.sv
// Package for the servo drive twin: record layout, drive modes, commands and sizes.
// Used by sdt_record_store and servo_drive_twin; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sdt_pkg;

    // Table size.
    localparam int AXES            = 4;
    localparam int DRIVES_PER_AXIS = 2;
    localparam int RECORDS         = AXES * DRIVES_PER_AXIS;
    localparam int REC_W           = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    // Gain registers, one per axis slot of the configuration map.
    localparam int GAIN_REGS = 4;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Item commands.
    localparam logic CMD_STEP   = 1'b0;
    localparam logic CMD_INJECT = 1'b1;

    // Mirror state machine modes.
    typedef enum logic [2:0] {
        MODE_DISABLED    = 3'd0,
        MODE_READY       = 3'd1,
        MODE_SWITCHED_ON = 3'd2,
        MODE_OP_ENABLED  = 3'd3,
        MODE_FAULT       = 3'd4
    } t_mode;

    // One drive record as held in the table.
    typedef struct packed {
        t_mode       mode;
        logic [15:0] prev_control;
        logic        fault_pending;
        logic [31:0] last_stamp;
        logic [31:0] position;
        logic [31:0] held_target;
        logic        reached;
    } t_record;

    localparam t_record RECORD_RESET = '{
        mode:          MODE_DISABLED,
        prev_control:  16'h0000,
        fault_pending: 1'b0,
        last_stamp:    32'h0000_0000,
        position:      32'h0000_0000,
        held_target:   32'h0000_0000,
        reached:       1'b0
    };

endpackage

`default_nettype wire

### hdl/sdt_record_store.sv
// Drive record table: one synchronous memory with a registered read port and a write port.
// Entries never written since reset read as the reset record. Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdt_record_store (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_rd_en,
    input  wire [sdt_pkg::REC_W-1:0] i_rd_addr,
    output sdt_pkg::t_record         o_rd_data,
    input  wire                      i_wr_en,
    input  wire [sdt_pkg::REC_W-1:0] i_wr_addr,
    input  sdt_pkg::t_record         i_wr_data
);

    sdt_pkg::t_record                 r_mem [sdt_pkg::RECORDS];
    logic [sdt_pkg::RECORDS-1:0]      r_valid;
    sdt_pkg::t_record                 r_rd_data;
    logic                             r_rd_hit;

    // Memory array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : sdt_pkg::RECORD_RESET;

endmodule

`default_nettype wire

### hdl/servo_drive_twin.sv
// Top level of the servo drive twin: command sequencer, mirror state machine and servo step.
// Depends on sdt_pkg and sdt_record_store.
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------------------------
//  item in   start, busy            i_command, i_axis_index, i_drive_index,
//                                   i_control_word, i_target_position, i_cycle_stamp
//  result    o_result_valid         o_index_error, o_status_word, o_position,
//                                   o_follow_error
//  config    i_cfg_we               i_cfg_index, i_cfg_data
//
// From accept to the next possible accept an item passes table read, mode
// and multiply, position add, write-back and report. The result beat appears on the
// cycle after write-back, for exactly one cycle, while the block is idle again.
// The read-modify-write of the record table keeps one item at work at a time.
// Reset is synchronous and active low; it restores all gains and marks every record as reset.
// The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
`default_nettype none

module servo_drive_twin (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_command,
    input  wire         [2:0]                  i_axis_index,
    input  wire         [1:0]                  i_drive_index,
    input  wire         [15:0]                 i_control_word,
    input  wire  signed [31:0]                 i_target_position,
    input  wire         [31:0]                 i_cycle_stamp,
    input  wire                                i_cfg_we,
    input  wire         [sdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire         [sdt_pkg::GAIN_W-1:0]  i_cfg_data,
    output logic                               o_result_valid,
    output logic                               o_index_error,
    output logic        [15:0]                 o_status_word,
    output logic signed [31:0]                 o_position,
    output logic signed [31:0]                 o_follow_error
);

    // Control word fields.
    localparam logic [3:0] CW_SHUTDOWN   = 4'h6;
    localparam logic [3:0] CW_SWITCH_ON  = 4'h7;
    localparam logic [3:0] CW_ENABLE_OP  = 4'hF;
    localparam logic [3:0] CW_DISABLE    = 4'h0;
    localparam int         CW_FAULT_RST  = 7;

    // Status word codes.
    localparam logic [15:0] SW_DISABLED    = 16'h0040;
    localparam logic [15:0] SW_READY       = 16'h0021;
    localparam logic [15:0] SW_POWERED     = 16'h0023;
    localparam logic [15:0] SW_OPERATING   = 16'h0027;
    localparam logic [15:0] SW_FAULT       = 16'h0008;
    localparam logic [15:0] SW_REACHED     = 16'h0400;

    localparam logic [15:0] GAIN_RESET = 16'd13107;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_MOVE,
        S_REPORT
    } t_state;

    t_state                      r_state;
    logic [sdt_pkg::GAIN_W-1:0]  r_gain [sdt_pkg::GAIN_REGS];

    // Latched item.
    logic                        r_cmd;
    logic [1:0]                  r_gain_sel;
    logic [15:0]                 r_cw;
    logic [31:0]                 r_target;
    logic [31:0]                 r_stamp;
    logic                        r_idx_err;
    logic [sdt_pkg::REC_W-1:0]   r_addr;

    // Working record and servo product.
    sdt_pkg::t_record            r_rec;
    logic signed [49:0]          r_prod;
    logic                        r_move;

    logic                        n_idx_err;
    logic [sdt_pkg::REC_W-1:0]   n_addr;
    sdt_pkg::t_record            rd_rec;
    sdt_pkg::t_record            n_rec;
    logic signed [49:0]          n_prod;
    logic                        n_move;
    logic signed [32:0]          err;
    logic                        near;
    logic [31:0]                 pos_new;
    logic                        mem_rd_en;
    logic                        mem_wr_en;

    // Next mode of the mirror state machine from the low control nibble, or the fault reset edge.
    function automatic sdt_pkg::t_mode f_next_mode(sdt_pkg::t_mode cur, logic [15:0] last,
                                                   logic [15:0] cw);
        logic [3:0]     low;
        sdt_pkg::t_mode nxt;
        low = cw[3:0];
        nxt = cur;
        unique case (cur)
            sdt_pkg::MODE_FAULT: begin
                if (cw[CW_FAULT_RST] && !last[CW_FAULT_RST]) nxt = sdt_pkg::MODE_DISABLED;
            end
            sdt_pkg::MODE_READY: begin
                if (low == CW_SWITCH_ON)      nxt = sdt_pkg::MODE_SWITCHED_ON;
                else if (low == CW_ENABLE_OP) nxt = sdt_pkg::MODE_OP_ENABLED;
                else if (low == CW_DISABLE)   nxt = sdt_pkg::MODE_DISABLED;
            end
            sdt_pkg::MODE_SWITCHED_ON: begin
                if (low == CW_ENABLE_OP)      nxt = sdt_pkg::MODE_OP_ENABLED;
                else if (low == CW_SHUTDOWN)  nxt = sdt_pkg::MODE_READY;
            end
            sdt_pkg::MODE_OP_ENABLED: begin
                if (low == CW_SWITCH_ON)      nxt = sdt_pkg::MODE_SWITCHED_ON;
                else if (low == CW_SHUTDOWN)  nxt = sdt_pkg::MODE_READY;
            end
            default: begin
                // Switch on disabled, and any code that should never be stored.
                nxt = (low == CW_SHUTDOWN) ? sdt_pkg::MODE_READY : sdt_pkg::MODE_DISABLED;
            end
        endcase
        return nxt;
    endfunction

    // Status word of a mode, with target reached shown only in operation enabled.
    function automatic logic [15:0] f_status(sdt_pkg::t_mode mode, logic reached);
        logic [15:0] sw;
        unique case (mode)
            sdt_pkg::MODE_DISABLED:    sw = SW_DISABLED;
            sdt_pkg::MODE_READY:       sw = SW_READY;
            sdt_pkg::MODE_SWITCHED_ON: sw = SW_POWERED;
            sdt_pkg::MODE_OP_ENABLED:  sw = SW_OPERATING | (reached ? SW_REACHED : 16'h0000);
            sdt_pkg::MODE_FAULT:       sw = SW_FAULT;
            default:                   sw = 16'h0000;
        endcase
        return sw;
    endfunction

    // Record select and range check at accept.
    always_comb begin
        n_idx_err = (32'(i_axis_index) >= 32'(sdt_pkg::AXES)) ||
                    (32'(i_drive_index) >= 32'(sdt_pkg::DRIVES_PER_AXIS));
        n_addr    = sdt_pkg::REC_W'(32'(i_axis_index) * sdt_pkg::DRIVES_PER_AXIS +
                                    32'(i_drive_index));
    end

    assign busy      = (r_state != S_IDLE);
    assign mem_rd_en = (r_state == S_READ);
    assign mem_wr_en = (r_state == S_REPORT) && !r_idx_err;

    sdt_record_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_rec),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (r_rec)
    );

    // Fault injection, mode update, once-per-stamp motion decision and the servo multiply.
    always_comb begin
        n_rec  = rd_rec;
        n_move = 1'b0;
        err    = $signed({r_target[31], r_target}) -
                 $signed({rd_rec.position[31], rd_rec.position});
        near   = (err == 33'sd0) || (err == 33'sd1) || (err == -33'sd1);
        n_prod = err * $signed({1'b0, r_gain[r_gain_sel]});
        if (r_cmd == sdt_pkg::CMD_INJECT) begin
            n_rec.fault_pending = 1'b1;
        end else begin
            // A pending fault is consumed as the drive enters fault.
            if (rd_rec.fault_pending) begin
                n_rec.mode          = sdt_pkg::MODE_FAULT;
                n_rec.fault_pending = 1'b0;
            end else begin
                n_rec.mode = f_next_mode(rd_rec.mode, rd_rec.prev_control, r_cw);
            end
            n_rec.prev_control = r_cw;
            if (rd_rec.last_stamp != r_stamp) begin
                n_rec.last_stamp = r_stamp;
                if (n_rec.mode == sdt_pkg::MODE_OP_ENABLED) begin
                    n_rec.held_target = r_target;
                    n_rec.reached     = near;
                    n_move            = 1'b1;
                end else begin
                    n_rec.reached = 1'b0;
                end
            end
        end
    end

    // Floor of the scaled step comes from the arithmetic shift of the product.
    assign pos_new = r_rec.position + r_prod[47:16];

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < sdt_pkg::GAIN_REGS; g++) begin
                r_gain[g] <= GAIN_RESET;
            end
        end else if (i_cfg_we) begin
            r_gain[i_cfg_index] <= i_cfg_data;
        end
    end

    // Sequencer with the item, working record and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_command;
                        r_gain_sel <= i_axis_index[1:0];
                        r_cw       <= i_control_word;
                        r_target   <= i_target_position;
                        r_stamp    <= i_cycle_stamp;
                        r_idx_err  <= n_idx_err;
                        r_addr     <= n_addr;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_rec   <= n_rec;
                    r_prod  <= n_prod;
                    r_move  <= n_move;
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if (r_move) begin
                        r_rec.position <= pos_new;
                    end
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    o_result_valid <= 1'b1;
                    o_index_error  <= r_idx_err;
                    if (r_idx_err) begin
                        o_status_word  <= 16'h0000;
                        o_position     <= 32'sd0;
                        o_follow_error <= 32'sd0;
                    end else begin
                        o_status_word  <= f_status(r_rec.mode, r_rec.reached);
                        o_position     <= r_rec.position;
                        o_follow_error <= r_rec.held_target - r_rec.position;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
